### rtl/core/crc8_register_write_framer_defines.svh
// ----------------------------------------------------------------------------
// CRC-8 register write framer: assertion macros
// Clocked assertion helpers used by the framer datapath.
// ----------------------------------------------------------------------------
`ifndef CRC8_REGISTER_WRITE_FRAMER_DEFINES_SVH
`define CRC8_REGISTER_WRITE_FRAMER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled in reset
`define CRC8RWF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled in reset
`define CRC8RWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRC8RWF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CRC8RWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/crc8rwf_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 register write framer package
// Types, constants and the byte-wise CRC-8 update shared by the framer.
// ----------------------------------------------------------------------------
package crc8rwf_pkg;

    localparam int HEADER_BYTES = 2;
    localparam int CRC_BYTES    = 1;
    localparam int VALUE_BYTES  = 4;
    localparam logic [7:0] CRC_POLY_RESET = 8'h07;
    localparam logic [7:0] CRC_TOP_BIT    = 8'h80;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_LEN,
        ST_DATA,
        ST_CRC
    } state_t;

    // source of the next frame byte
    typedef enum logic [1:0] {
        SRC_HEAD,
        SRC_LEN,
        SRC_DATA,
        SRC_CRC
    } src_sel_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        src_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic bad;
        logic data_last;
    } dp_status_t;

    // MSB-first CRC-8 over one byte, initial crc given, leading bit implied
    function automatic logic [7:0] crc8_update(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_TOP_BIT) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/crc8rwf_ctrl.sv
// ----------------------------------------------------------------------------
// CRC-8 register write framer controller
// Sequences one request: header byte (or error beat), length, data, CRC.
// ----------------------------------------------------------------------------
module crc8rwf_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output crc8rwf_pkg::dp_cmd_t    cmd,
    input  crc8rwf_pkg::dp_status_t status
);
    import crc8rwf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // advance one frame byte each time the output slot is free
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (status.slot_free)
                begin
                    state_next = status.bad ? ST_IDLE : ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (status.slot_free && status.data_last)
                begin
                    state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // drive handshake and datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        cmd.sel  = SRC_HEAD;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_HEAD:
            begin
                cmd.emit = status.slot_free;
                cmd.sel  = SRC_HEAD;
            end
            ST_LEN:
            begin
                cmd.emit = status.slot_free;
                cmd.sel  = SRC_LEN;
            end
            ST_DATA:
            begin
                cmd.emit = status.slot_free;
                cmd.sel  = SRC_DATA;
            end
            ST_CRC:
            begin
                cmd.emit = status.slot_free;
                cmd.sel  = SRC_CRC;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/crc8rwf_dp.sv
// ----------------------------------------------------------------------------
// CRC-8 register write framer datapath
// Request registers, running CRC, polynomial register and output register.
// ----------------------------------------------------------------------------
`include "crc8_register_write_framer_defines.svh"

module crc8rwf_dp #(
    parameter int MAX_FRAME_BYTES = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [7:0]              cfg_wr_data,
    input  logic [7:0]              reg_id,
    input  logic [2:0]              data_length,
    input  logic [31:0]             value,
    input  crc8rwf_pkg::dp_cmd_t    cmd,
    output crc8rwf_pkg::dp_status_t status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              frame_byte,
    output logic                    last,
    output logic                    error
);
    import crc8rwf_pkg::*;

    logic [7:0]  poly_reg;
    logic [7:0]  id_reg;
    logic [2:0]  len_reg;
    logic [31:0] val_reg;
    logic        bad_reg;
    logic [2:0]  cnt_reg;
    logic [7:0]  crc_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        error_reg;

    logic [7:0]  byte_next;
    logic        last_next;
    logic        error_next;
    logic [7:0]  crc_next;
    logic        bad_in;

    // reject empty, oversized or over-buffer requests
    assign bad_in = (data_length == 3'd0)
                 || (int'(data_length) > VALUE_BYTES)
                 || (int'(data_length) + HEADER_BYTES + CRC_BYTES > MAX_FRAME_BYTES);

    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.bad       = bad_reg;
    assign status.data_last = (cnt_reg == (len_reg - 3'd1));

    // hold the polynomial
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RESET;
        end
        else if (cfg_wr_en)
        begin
            poly_reg <= cfg_wr_data;
        end
    end

    // select the next frame byte and its CRC contribution
    always_comb
    begin
        byte_next  = 8'h00;
        last_next  = 1'b0;
        error_next = 1'b0;
        crc_next   = crc_reg;
        case (cmd.sel)
            SRC_HEAD:
            begin
                if (bad_reg)
                begin
                    last_next  = 1'b1;
                    error_next = 1'b1;
                end
                else
                begin
                    byte_next = id_reg;
                end
            end
            SRC_LEN:
            begin
                byte_next = {5'd0, len_reg};
            end
            SRC_DATA:
            begin
                byte_next = val_reg[7:0];
            end
            SRC_CRC:
            begin
                byte_next = crc_reg;
                last_next = 1'b1;
            end
            default:
            begin
                byte_next = 8'h00;
            end
        endcase
        if (cmd.sel != SRC_CRC)
        begin
            crc_next = crc8_update(crc_reg, byte_next, poly_reg);
        end
    end

    // capture the request and walk through it
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg  <= reg_id;
            len_reg <= data_length;
            val_reg <= value;
            bad_reg <= bad_in;
            cnt_reg <= 3'd0;
            crc_reg <= 8'h00;
        end
        else if (cmd.emit)
        begin
            crc_reg <= crc_next;
            if (cmd.sel == SRC_DATA)
            begin
                val_reg <= {8'h00, val_reg[31:8]};
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            byte_reg  <= byte_next;
            last_reg  <= last_next;
            error_reg <= error_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last       = last_reg;
    assign error      = error_reg;

    `CRC8RWF_ASSERT_IMPL(a_emit_slot_free, clk, rst_n, cmd.emit, status.slot_free, "beat issued into a full output register")
    `CRC8RWF_ASSERT_IMPL(a_error_beat_form, clk, rst_n, out_valid_reg && error_reg, last_reg && (byte_reg == 8'h00), "error beat not marked last or not zero")
    `CRC8RWF_ASSERT_NEXT(a_load_clears_crc, clk, rst_n, cmd.load, (crc_reg == 8'h00) && (cnt_reg == 3'd0), "request load did not clear CRC and count")

endmodule

### rtl/core/crc8_register_write_framer.sv
// ----------------------------------------------------------------------------
// CRC-8 register write framer
// Turns one register write request into a framed byte stream: id, length,
// data bytes (least significant first), then an MSB-first CRC-8 over them.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   cfg     | cfg_wr_en, cfg_wr_data                   | in
//   in      | in_valid/in_ready, reg_id, data_length,  | in
//           | value                                    |
//   out     | out_valid/out_ready, frame_byte, last,   | out
//           | error                                    |
//
// A request is accepted, then issued as one beat per frame byte from the
// controller's byte sequencer; an error request is accepted, then issued as
// a single error beat. The next request is accepted after the last beat
// has been issued into the output register. Downstream stalls hold the
// sequencer. Reset sets the polynomial to 0x07 and empties the output register.
// ----------------------------------------------------------------------------
module crc8_register_write_framer #(
    parameter int MAX_FRAME_BYTES = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  reg_id,
    input  logic [2:0]  data_length,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last,
    output logic        error
);
    import crc8rwf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequence the frame
    crc8rwf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // hold the request, CRC and output beat
    crc8rwf_dp #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .reg_id      (reg_id),
        .data_length (data_length),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .last        (last),
        .error       (error)
    );

endmodule
